// ===== hdl/bspline_velocity_energy_objective_unit_assert.svh =====
// ---------------------------------------------------------------------------
// B-spline velocity objective assertion macros
// Concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef BSPLINE_VELOCITY_ENERGY_OBJECTIVE_UNIT_ASSERT_SVH
`define BSPLINE_VELOCITY_ENERGY_OBJECTIVE_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is high
`define BSVE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds during reset
`define BSVE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bsve_pkg.sv =====
// ---------------------------------------------------------------------------
// B-spline velocity objective package
// Widths, payload structs and the product weighting shared by the modules.
// ---------------------------------------------------------------------------
package bsve_pkg;

   // Path geometry
   localparam int DIMENSIONS = 3;
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = 2;
   localparam int WIN_DEPTH  = 3;

   // Result widths
   localparam int VALUE_W = 64;
   localparam int SUM_W   = 63;

   // Shared multiplier: operands hold p0-3p1+3p2-p3 of 32-bit points
   localparam int OPND_W = 35;
   localparam int PROD_W = 2 * OPND_W;

   // Weighted sum of six products, wide enough to pick 64 bits above FRAC_BITS+2
   localparam int ACC_W = (FRAC_BITS + 66 > 77) ? FRAC_BITS + 66 : 77;

   // Division by 15, one 16-bit digit per step, by reciprocal and one correction
   localparam int          DIGIT_W     = 16;
   localparam int          NUM_DIGITS  = 4;
   localparam int          REM_W       = 4;
   localparam int          CUR_W       = DIGIT_W + REM_W;
   localparam int          DIVISOR     = 15;
   localparam int          RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP15     = 21'd1118481;

   // Product order of one axis term
   typedef enum logic [2:0] {
      PRD_UU = 3'd0,
      PRD_WU = 3'd1,
      PRD_WW = 3'd2,
      PRD_HU = 3'd3,
      PRD_HW = 3'd4,
      PRD_HH = 3'd5
   } prod_sel_type;

   typedef struct packed {
      logic                               last;
      logic [NUM_AXES-1:0][COORD_W-1:0]   coord;
   } point_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               too_few;
      logic               saturated;
   } result_type;

   // Weight a product by its term coefficient: 3, -15, 20, 10, -30, 15
   function automatic logic signed [ACC_W-1:0] scale_product(
      prod_sel_type              sel,
      logic signed [PROD_W-1:0]  p
   );
      logic signed [ACC_W-1:0] e;
      e = ACC_W'(p);
      case (sel)
         PRD_UU:  return (e <<< 1) + e;
         PRD_WU:  return e - (e <<< 4);
         PRD_WW:  return (e <<< 4) + (e <<< 2);
         PRD_HU:  return (e <<< 3) + (e <<< 1);
         PRD_HW:  return (e <<< 1) - (e <<< 5);
         PRD_HH:  return (e <<< 4) - e;
         default: return '0;
      endcase
   endfunction

endpackage

// ===== hdl/bspline_velocity_energy_objective_unit.sv =====
// ---------------------------------------------------------------------------
// B-spline velocity objective unit
// Squared-velocity integral of a cubic B-spline path, accumulated over
// control points streamed in one at a time.
// ---------------------------------------------------------------------------
// Once three earlier points are held, each axis of a control point runs six
// weighted products of U, W and H and four division digits, each a multiply
// state and a fix state, all through the one 35 x 35 multiplier, then one add
// into the running sum. The first three points of a path only shift the window.
// The block takes no request while a point is in work. A point marked last then
// hands the result to the output register in the emit state, which waits for as
// long as an earlier result still waits there for rsp_tready. Once handed over,
// a result waits in the output register without holding up the next request.
module bspline_velocity_energy_objective_unit
   import bsve_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,  // coord_x, coord_y, coord_z
   input  logic                  req_tlast,  // last_point
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_W-1:0]    rsp_tdata,  // objective_value
   output logic [1:0]            rsp_tuser,  // too_few_points, saturated
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [VALUE_W-1:0]    csr_pwdata,
   output logic [VALUE_W-1:0]    csr_prdata,
   output logic                  csr_pready
);

   localparam logic CSR_IDX_ADDEND = 1'b0;

   logic signed [VALUE_W-1:0]  addend_ff, addend_in;
   result_type                 rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   point_type                  point;
   logic                       start;
   logic                       idle;
   logic                       emit_valid;
   logic                       emit_ready;
   result_type                 result;
   logic signed [OPND_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic                       csr_write;

   // Unpack the request
   assign point.coord[0] = req_tdata[31:0];
   assign point.coord[1] = req_tdata[63:32];
   assign point.coord[2] = req_tdata[95:64];
   assign point.last     = req_tlast;

   assign req_tready = idle;
   assign start      = req_tvalid & req_tready;

   // Configuration write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign addend_in  = (csr_write && csr_paddr[3] == CSR_IDX_ADDEND) ?
                       signed'(csr_pwdata) : addend_ff;
   assign csr_prdata = (csr_paddr[3] == CSR_IDX_ADDEND) ? addend_ff : '0;

   // Output register: load a finished result, drop it when taken
   assign emit_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid && emit_ready) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.value;
   assign rsp_tuser[0] = rsp_ff.too_few;
   assign rsp_tuser[1] = rsp_ff.saturated;

   always_ff @(posedge clock) begin
      if (reset) begin
         addend_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addend_ff    <= addend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   bsve_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .point_in   (point),
      .idle       (idle),
      .addend     (addend_ff),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .result     (result),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_p      (mul_p)
   );

   bsve_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

endmodule

// ===== hdl/bsve_mul.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 35 x 35 multiplier with a registered product, used for the term
// products and for the reciprocal step of the division.
// ---------------------------------------------------------------------------
module bsve_mul
   import bsve_pkg::*;
(
   input  logic                      clock,
   input  logic signed [OPND_W-1:0]  mul_a,
   input  logic signed [OPND_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // Multiply
   assign prod_in = mul_a * mul_b;

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hdl/bsve_seq.sv =====
// ---------------------------------------------------------------------------
// Objective sequencer
// Holds the point window and the running sum, and walks each axis through
// six weighted products and a four-digit division by 60 on the shared
// multiplier.
// ---------------------------------------------------------------------------
module bsve_seq
   import bsve_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  point_type                 point_in,
   output logic                      idle,
   input  logic signed [VALUE_W-1:0] addend,
   output logic                      emit_valid,
   input  logic                      emit_ready,
   output result_type                result,
   output logic signed [OPND_W-1:0]  mul_a,
   output logic signed [OPND_W-1:0]  mul_b,
   input  logic signed [PROD_W-1:0]  mul_p
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_MUL   = 9'b000000100,
      ST_DRAIN = 9'b000001000,
      ST_DIVM  = 9'b000010000,
      ST_DIVF  = 9'b000100000,
      ST_SUM   = 9'b001000000,
      ST_SHIFT = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   localparam logic [1:0]         SEEN_FULL = 2'd3;
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   state_type                  state_ff, state_in;
   logic [AXIS_W-1:0]          axis_ff, axis_in;
   prod_sel_type               k_ff, k_in;
   prod_sel_type               pk_ff, pk_in;
   logic [1:0]                 dig_ff, dig_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [CUR_W-1:0]           cur_ff, cur_in;
   logic [VALUE_W-1:0]         q_ff, q_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [OPND_W-1:0]   u_ff, u_in, w_ff, w_in, h_ff, h_in;
   point_type                  pt_ff, pt_in;
   logic signed [COORD_W-1:0]  win_ff [NUM_AXES][WIN_DEPTH];
   logic signed [COORD_W-1:0]  win_in [NUM_AXES][WIN_DEPTH];
   logic [1:0]                 seen_ff, seen_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic                       ovf_ff, ovf_in;
   logic                       few_ff, few_in;

   logic signed [OPND_W-1:0]   p0, p1, p2, p3;
   logic signed [OPND_W-1:0]   u_calc, w_calc, h_calc;
   logic [VALUE_W-1:0]         mval;
   logic [DIGIT_W-1:0]         digit;
   logic [CUR_W-1:0]           cur_calc;
   logic [DIGIT_W-1:0]         q_est;
   logic [CUR_W:0]             q_times15;
   logic [CUR_W:0]             r_full;
   logic [CUR_W:0]             r_sel;
   logic                       r_fix;
   logic [DIGIT_W-1:0]         q_digit;
   logic [SUM_W+1:0]           sum_ext;
   logic signed [VALUE_W:0]    fin;
   logic                       fin_ovf;

   // Window taps and new point of the current axis
   assign p0 = OPND_W'(win_ff[axis_ff][0]);
   assign p1 = OPND_W'(win_ff[axis_ff][1]);
   assign p2 = OPND_W'(win_ff[axis_ff][2]);
   assign p3 = OPND_W'(signed'(pt_ff.coord[axis_ff]));

   // U = p0-3p1+3p2-p3, W = p0-2p1+p2, H = p0-p2
   assign u_calc = p0 - (p1 <<< 1) - p1 + (p2 <<< 1) + p2 - p3;
   assign w_calc = p0 - (p1 <<< 1) + p2;
   assign h_calc = p0 - p2;

   // Dividend N >> (FRAC_BITS+2), taken most significant digit first
   assign mval     = acc_ff[FRAC_BITS+2 +: VALUE_W];
   assign digit    = mval[{~dig_ff, 4'b0000} +: DIGIT_W];
   assign cur_calc = {rem_ff, digit};

   // Quotient digit estimate is exact or one low; correct it once
   assign q_est     = mul_p[RECIP_SHIFT +: DIGIT_W];
   assign q_times15 = (CUR_W+1)'({q_est, 4'b0000}) - (CUR_W+1)'(q_est);
   assign r_full    = (CUR_W+1)'(cur_ff) - q_times15;
   assign r_fix     = r_full >= (CUR_W+1)'(DIVISOR);
   assign r_sel     = r_fix ? r_full - (CUR_W+1)'(DIVISOR) : r_full;
   assign q_digit   = r_fix ? q_est + DIGIT_W'(1) : q_est;

   // Running sum plus the new axis term
   assign sum_ext = (SUM_W+2)'(sum_ff) + (SUM_W+2)'(q_ff);

   // Final sum plus addend; only a positive addend can overflow
   assign fin     = signed'((VALUE_W+1)'(sum_ff)) + (VALUE_W+1)'(addend);
   assign fin_ovf = !fin[VALUE_W] && fin[VALUE_W-1];

   assign result.value     = fin_ovf ? VALUE_MAX : fin[VALUE_W-1:0];
   assign result.too_few   = few_ff;
   assign result.saturated = ovf_ff | fin_ovf;

   assign idle       = (state_ff == ST_IDLE);
   assign emit_valid = (state_ff == ST_EMIT);

   // Drive the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            case (k_ff)
               PRD_UU:  begin mul_a = u_ff; mul_b = u_ff; end
               PRD_WU:  begin mul_a = w_ff; mul_b = u_ff; end
               PRD_WW:  begin mul_a = w_ff; mul_b = w_ff; end
               PRD_HU:  begin mul_a = h_ff; mul_b = u_ff; end
               PRD_HW:  begin mul_a = h_ff; mul_b = w_ff; end
               PRD_HH:  begin mul_a = h_ff; mul_b = h_ff; end
               default: begin mul_a = '0;   mul_b = '0;   end
            endcase
         end
         ST_DIVM: begin
            mul_a = signed'(OPND_W'(cur_calc));
            mul_b = signed'(OPND_W'(RECIP15));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequence one point
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      k_in     = k_ff;
      pk_in    = pk_ff;
      dig_in   = dig_ff;
      rem_in   = rem_ff;
      cur_in   = cur_ff;
      q_in     = q_ff;
      acc_in   = acc_ff;
      u_in     = u_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      pt_in    = pt_ff;
      win_in   = win_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      few_in   = few_ff;
      case (state_ff)
         ST_IDLE: begin
            // take a point; run the terms once the window is full
            if (start) begin
               pt_in   = point_in;
               axis_in = '0;
               state_in = (seen_ff == SEEN_FULL) ? ST_LOAD : ST_SHIFT;
            end
         end
         ST_LOAD: begin
            u_in     = u_calc;
            w_in     = w_calc;
            h_in     = h_calc;
            acc_in   = '0;
            k_in     = PRD_UU;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // issue one product, accumulate the one before
            if (k_ff != PRD_UU) begin
               acc_in = acc_ff + scale_product(pk_ff, mul_p);
            end
            pk_in = k_ff;
            if (k_ff == PRD_HH) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = prod_sel_type'(k_ff + 3'd1);
            end
         end
         ST_DRAIN: begin
            acc_in   = acc_ff + scale_product(pk_ff, mul_p);
            dig_in   = '0;
            rem_in   = '0;
            state_in = ST_DIVM;
         end
         ST_DIVM: begin
            cur_in   = cur_calc;
            state_in = ST_DIVF;
         end
         ST_DIVF: begin
            q_in   = {q_ff[VALUE_W-DIGIT_W-1:0], q_digit};
            rem_in = r_sel[REM_W-1:0];
            dig_in = dig_ff + 2'd1;
            state_in = (dig_ff == 2'(NUM_DIGITS-1)) ? ST_SUM : ST_DIVM;
         end
         ST_SUM: begin
            // add the axis term, saturating at the largest sum
            if (sum_ext[SUM_W+1:SUM_W] != 2'b00) begin
               sum_in = SUM_MAX;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_ext[SUM_W-1:0];
            end
            if (axis_ff == AXIS_W'(DIMENSIONS-1)) begin
               state_in = ST_SHIFT;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_SHIFT: begin
            // advance the window by the new point
            for (int a = 0; a < NUM_AXES; a++) begin
               win_in[a][0] = win_ff[a][1];
               win_in[a][1] = win_ff[a][2];
               win_in[a][2] = signed'(pt_ff.coord[a]);
            end
            few_in = (seen_ff != SEEN_FULL);
            if (seen_ff != SEEN_FULL) begin
               seen_in = seen_ff + 2'd1;
            end
            state_in = pt_ff.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // hand over the result and start a fresh path
            if (emit_ready) begin
               seen_in  = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         few_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         few_ff   <= few_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      k_ff    <= k_in;
      pk_ff   <= pk_in;
      dig_ff  <= dig_in;
      rem_ff  <= rem_in;
      cur_ff  <= cur_in;
      q_ff    <= q_in;
      acc_ff  <= acc_in;
      u_ff    <= u_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
      pt_ff   <= pt_in;
      win_ff  <= win_in;
   end

endmodule

// ===== hdl/bsve_checker.sv =====
// ---------------------------------------------------------------------------
// B-spline velocity objective checker
// Port-level assertions on the objective unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "bspline_velocity_energy_objective_unit_assert.svh"

module bsve_checker
   import bsve_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [VALUE_W-1:0]  rsp_tdata,
   input logic [1:0]          rsp_tuser
);

   // No result survives reset
   `BSVE_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")

   // A stalled result holds
   `BSVE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Ready falls after every taken request, while the sequencer is busy
   `BSVE_ASSERT(a_busy_after_request, clock, reset, req_tvalid && req_tready |=> !req_tready, "ready right after a request")

   // A short path has an empty sum and cannot saturate
   `BSVE_ASSERT(a_short_path_unsaturated, clock, reset, rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1], "short path flagged saturated")

endmodule

bind bspline_velocity_energy_objective_unit bsve_checker u_bsve_checker (.*);

// ===== tb/tb_bspline_velocity_energy_objective_unit.sv =====
// ---------------------------------------------------------------------------
// B-spline velocity objective unit testbench
// Streams control-point paths into the unit and checks every objective
// result against a cycle-free predictor of the interval energy sum, under
// several addend settings and with random idling on both stream sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bspline_velocity_energy_objective_unit;
   import bsve_pkg::*;

   localparam int RUN_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASE_ITEMS   = 190;

   localparam logic [3:0] ADDR_SCALE_ADDEND = 4'h0;
   localparam logic [3:0] ADDR_UNMAPPED     = 4'h8;

   localparam logic signed [63:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN     = 64'sh8000_0000_0000_0000;
   localparam logic        [63:0] Q_MAX_U   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

   typedef enum int {
      STYLE_WIDE,
      STYLE_NARROW,
      STYLE_CORNER,
      STYLE_WALK
   } coord_style_e;

   // DUT ports
   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata   = '0;  // coord_x, coord_y, coord_z
   logic          req_tlast   = 1'b0; // last_point
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [63:0]   rsp_tdata;          // objective_value
   logic [1:0]    rsp_tuser;          // too_few_points, saturated
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [3:0]    csr_paddr   = '0;
   logic [63:0]   csr_pwdata  = '0;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   // Predictor state
   logic signed [31:0] knot_win [3][3];
   int                 knots_held;
   logic        [63:0] energy_sum;
   logic               energy_clipped;
   logic signed [63:0] energy_addend;

   point_type  point_backlog[$];
   result_type expected_objectives[$];
   point_type  point_on_bus;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   bspline_velocity_energy_objective_unit DUT (.*);

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Squared-velocity integral of one interval on one axis, floored
   function automatic logic [63:0] interval_energy(longint p0, longint p1,
                                                   longint p2, longint p3);
      longint             uu, ww, hh;
      logic signed [127:0] u, w, h, n, q;
      uu = p0 - 3 * p1 + 3 * p2 - p3;
      ww = p0 - 2 * p1 + p2;
      hh = p0 - p2;
      u = uu;
      w = ww;
      h = hh;
      n = 3 * u * u - 15 * w * u + 20 * w * w + 10 * h * u - 30 * h * w + 15 * h * h;
      q = (n >>> FRAC_BITS) / 60;
      return q[63:0];
   endfunction

   task automatic clear_path();
      for (int a = 0; a < 3; a++)
         for (int k = 0; k < 3; k++)
            knot_win[a][k] = '0;
      knots_held     = 0;
      energy_sum     = '0;
      energy_clipped = 1'b0;
   endtask

   // Advance the predictor by one accepted point
   task automatic accumulate_point(point_type pt);
      logic        [63:0] t;
      logic signed [63:0] s;
      logic               few;
      logic               sat;
      result_type         r;
      if (knots_held >= 3) begin
         for (int a = 0; a < DIMENSIONS; a++) begin
            t = interval_energy(knot_win[a][0], knot_win[a][1], knot_win[a][2],
                                $signed(pt.coord[a]));
            if (energy_sum > Q_MAX_U - t) begin
               energy_sum     = Q_MAX_U;
               energy_clipped = 1'b1;
            end else begin
               energy_sum = energy_sum + t;
            end
         end
      end
      for (int a = 0; a < 3; a++) begin
         knot_win[a][0] = knot_win[a][1];
         knot_win[a][1] = knot_win[a][2];
         knot_win[a][2] = pt.coord[a];
      end
      few = (knots_held < 3);
      if (knots_held < 3)
         knots_held++;
      if (!pt.last)
         return;
      s   = energy_sum;
      sat = energy_clipped;
      if (energy_addend > 0 && s > Q_MAX - energy_addend) begin
         s   = Q_MAX;
         sat = 1'b1;
      end else begin
         s = s + energy_addend;
      end
      r.value     = s;
      r.too_few   = few;
      r.saturated = sat;
      expected_objectives.push_back(r);
      clear_path();
   endtask

   function automatic void queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic is_last);
      point_type pt;
      pt.coord[0] = x;
      pt.coord[1] = y;
      pt.coord[2] = z;
      pt.last     = is_last;
      point_backlog.push_back(pt);
   endfunction

   function automatic logic signed [31:0] pick_coord(coord_style_e style,
                                                     logic signed [31:0] prev);
      case (style)
         STYLE_WIDE:   return $urandom;
         STYLE_NARROW: return int'($urandom_range(131072)) - 65536;
         STYLE_CORNER: begin
            case ($urandom_range(5))
               0:       return COORD_MIN;
               1:       return COORD_MAX;
               2:       return 32'sd0;
               3:       return -32'sd1;
               4:       return 32'sd1;
               default: return $urandom;
            endcase
         end
         default:      return prev + (int'($urandom_range(8191)) - 4096);
      endcase
   endfunction

   // Queue one path of random length, mostly short
   function automatic int queue_random_path();
      int                 n;
      coord_style_e       style;
      logic signed [31:0] c [3];
      n     = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      style = coord_style_e'($urandom_range(3));
      for (int a = 0; a < 3; a++)
         c[a] = $urandom;
      for (int i = 0; i < n; i++) begin
         for (int a = 0; a < 3; a++)
            c[a] = pick_coord(style, c[a]);
         queue_point(c[0], c[1], c[2], i == n - 1);
      end
      return n;
   endfunction

   // Request driver: present backlog items, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            accumulate_point(point_on_bus);
         if (!req_tvalid || req_tready) begin
            if (point_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               point_on_bus = point_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= point_on_bus.coord;
               req_tlast  <= point_on_bus.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: stall at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Result monitor: compare against the oldest expected objective
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_objectives.size() == 0) begin
            $error("unexpected result: objective_value %0d", $signed(rsp_tdata));
            mismatches++;
         end else begin
            want = expected_objectives.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("objective_value: expected %0d, actual %0d",
                      $signed(want.value), $signed(rsp_tdata));
               mismatches++;
            end
            if (rsp_tuser[0] !== want.too_few) begin
               $error("too_few_points: expected %0b, actual %0b", want.too_few, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== want.saturated) begin
               $error("saturated: expected %0b, actual %0b", want.saturated, rsp_tuser[1]);
               mismatches++;
            end
         end
      end
   end

   // Register write: setup cycle, then access cycle until pready
   task automatic write_register(logic [3:0] addr, logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_SCALE_ADDEND)
         energy_addend = data;
   endtask

   // Hold until every request is taken and every result is back
   task automatic wait_drained();
      @(negedge clock);
      while (point_backlog.size() != 0 || req_tvalid || expected_objectives.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 68; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 68; end
         default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
   endtask

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("bspline_velocity_energy_objective_unit: mismatch");
      $finish;
   end

   initial begin
      logic [63:0] addend;
      int          queued;
      energy_addend = '0;
      clear_path();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed paths with the reset addend
      @(negedge clock);
      set_idling(0);
      // short paths of one, two and three points
      queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      queue_point(COORD_MAX, 32'sd0, -32'sd1, 1'b1);
      queue_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
      queue_point(-32'sd1, -32'sd1, -32'sd1, 1'b0);
      queue_point(32'sd1, 32'sd1, 32'sd1, 1'b1);
      // one interval with full-swing alternation on every axis
      queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
      queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      // flat path gives zero energy
      for (int i = 0; i < 5; i++)
         queue_point(32'sd0, 32'sd0, 32'sd0, i == 4);
      // mixed corners
      queue_point(COORD_MIN, COORD_MAX, 32'sd0, 1'b0);
      queue_point(COORD_MAX, 32'sd0, -32'sd1, 1'b0);
      queue_point(32'sd0, -32'sd1, 32'sd1, 1'b0);
      queue_point(-32'sd1, 32'sd1, 32'sh4000_0000, 1'b0);
      queue_point(32'sd1, 32'sh4000_0000, COORD_MIN, 1'b0);
      queue_point(32'sh4000_0000, COORD_MIN, COORD_MAX, 1'b0);
      queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      wait_drained();

      // Random phases, one addend setting and idling pattern each
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       addend = Q_MAX;
            1:       addend = Q_MIN;
            2:       addend = '1;
            3:       addend = 64'd1;
            4:       addend = Q_MAX - (64'sd1 <<< 40);
            5:       addend = {$urandom, $urandom};
            6:       addend = '0;
            default: addend = $signed({$urandom, $urandom}) >>> $urandom_range(40);
         endcase
         write_register(ADDR_SCALE_ADDEND, addend);
         // unmapped register must leave the addend alone
         if (ph == 3)
            write_register(ADDR_UNMAPPED, {$urandom, $urandom});
         @(negedge clock);
         set_idling(ph % 4);
         queued = 0;
         // final addition past the top of the range
         if (ph == 4) begin
            for (int i = 0; i < 5; i++)
               queue_point(i[0] ? COORD_MIN : COORD_MAX, i[0] ? COORD_MAX : COORD_MIN,
                           i[0] ? COORD_MIN : COORD_MAX, i == 4);
            queued = 5;
         end
         while (queued < PHASE_ITEMS)
            queued += queue_random_path();
         wait_drained();
      end

      if (mismatches == 0 && expected_objectives.size() == 0) begin
         $display("bspline_velocity_energy_objective_unit: match");
      end else begin
         $display("bspline_velocity_energy_objective_unit: mismatch");
      end
      $finish;
   end

endmodule
